### src/tkk_pkg.sv
// Shared constants and types for the top-k similarity keeper.
`timescale 1ns / 1ps
`default_nettype none

package tkk_pkg;

    // Default sizing
    localparam int CAPACITY_DEF        = 32;
    localparam int ID_BITS_DEF         = 32;
    localparam int SCORE_FRAC_BITS_DEF = 16;

    // Fixed field widths
    localparam int REF_BITS       = 32;
    localparam int KEEP_BITS      = 6;
    localparam int MIN_SIM_BITS   = 17;
    localparam int CFG_DATA_BITS  = 17;
    localparam int CFG_IDX_BITS   = 2;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_KEEP_COUNT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_SIM    = 2'd1;

    // Register reset values
    localparam logic [KEEP_BITS-1:0]    KEEP_COUNT_RST = 6'd20;
    localparam logic [MIN_SIM_BITS-1:0] MIN_SIM_RST    = 17'd1;

    // Request opcodes
    localparam logic OP_OFFER   = 1'b0;
    localparam logic OP_READOUT = 1'b1;

    // What every cell does this cycle
    typedef enum logic [1:0] {
        CM_HOLD   = 2'd0,
        CM_INSERT = 2'd1,
        CM_SHIFT  = 2'd2
    } cell_mode_t;

    // Per-cell control from the sequencer
    typedef struct packed {
        cell_mode_t mode;
        logic       occ;
    } cell_ctl_t;

endpackage

`default_nettype wire

### src/tkk_ifs.sv
// Valid/ready channel interfaces for requests and readout results.
`timescale 1ns / 1ps
`default_nettype none

interface tkk_req_if #(
    parameter int SCORE_BITS = 17,
    parameter int ID_BITS    = 32,
    parameter int REF_BITS   = 32
);
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [SCORE_BITS-1:0] score;
    logic [ID_BITS-1:0]    item_id;
    logic [REF_BITS-1:0]   owner_id;

    modport source (output valid, output op, output score, output item_id,
                    output owner_id, input ready);
    modport sink   (input valid, input op, input score, input item_id,
                    input owner_id, output ready);
endinterface

interface tkk_rsp_if #(
    parameter int SCORE_BITS = 17,
    parameter int ID_BITS    = 32,
    parameter int REF_BITS   = 32
);
    logic                  valid;
    logic                  ready;
    logic [REF_BITS-1:0]   ref_id;
    logic [ID_BITS-1:0]    entry_id;
    logic [SCORE_BITS-1:0] entry_score;
    logic                  last;

    modport source (output valid, output ref_id, output entry_id,
                    output entry_score, output last, input ready);
    modport sink   (input valid, input ref_id, input entry_id,
                    input entry_score, input last, output ready);
endinterface

`default_nettype wire

### src/tkk_cell.sv
// One slot of the sorted list: holds a (score, id) pair, inserts or shifts.
`timescale 1ns / 1ps
`default_nettype none

module tkk_cell
    import tkk_pkg::*;
#(
    parameter int SCORE_BITS = 17,
    parameter int ID_BITS    = 32
) (
    input  wire                   clk,
    input  wire  cell_ctl_t       ctl,
    input  wire  [SCORE_BITS-1:0] offer_score,
    input  wire  [ID_BITS-1:0]    offer_id,
    input  wire                   left_gt,
    input  wire  [SCORE_BITS-1:0] left_score,
    input  wire  [ID_BITS-1:0]    left_id,
    input  wire  [SCORE_BITS-1:0] right_score,
    input  wire  [ID_BITS-1:0]    right_id,
    output logic                  gt,
    output logic [SCORE_BITS-1:0] score,
    output logic [ID_BITS-1:0]    id
);

    logic [SCORE_BITS-1:0] score_reg;
    logic [ID_BITS-1:0]    id_reg;

    // Occupied and strictly better than the offer: this slot stays put
    assign gt    = ctl.occ && (score_reg > offer_score);
    assign score = score_reg;
    assign id    = id_reg;

    // Payload only, no reset
    always_ff @(posedge clk)
    begin
        unique case (ctl.mode)
            CM_INSERT:
            begin
                if (!gt)
                begin
                    // first slot not better takes the offer, the rest move down
                    if (left_gt)
                    begin
                        score_reg <= offer_score;
                        id_reg    <= offer_id;
                    end
                    else
                    begin
                        score_reg <= left_score;
                        id_reg    <= left_id;
                    end
                end
            end
            CM_SHIFT:
            begin
                score_reg <= right_score;
                id_reg    <= right_id;
            end
            default:
            begin
                score_reg <= score_reg;
                id_reg    <= id_reg;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/top_k_similarity_keeper_unit.sv
// Top level: sequencer, configuration and the chain of list cells.
//
//  channel | dir | handshake      | payload
//  --------+-----+----------------+--------------------------------------------
//  req     | in  | valid / ready  | op, score, item_id, owner_id
//  rsp     | out | valid / ready  | ref_id, entry_id, entry_score, last
//  cfg     | in  | cfg_we         | cfg_index, cfg_data
//
// For an offer, every cell compares against it at once and the chain
// inserts at the clock edge that accepts the request. A readout of N
// entries gives N result transactions as the chain shifts toward slot 0.
// req.ready is low while a readout drains; a stalled rsp holds the chain.
// Reset clears the fill count and loads the register defaults; slot contents
// are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module top_k_similarity_keeper_unit
    import tkk_pkg::*;
#(
    parameter int CAPACITY        = CAPACITY_DEF,
    parameter int ID_BITS         = ID_BITS_DEF,
    parameter int SCORE_FRAC_BITS = SCORE_FRAC_BITS_DEF
) (
    input  wire                     clk,
    input  wire                     rst_n,
    tkk_req_if.sink                 req,
    tkk_rsp_if.source               rsp,
    input  wire                     cfg_we,
    input  wire  [CFG_IDX_BITS-1:0] cfg_index,
    input  wire  [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int SCORE_BITS = SCORE_FRAC_BITS + 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int CMP_W      = (SCORE_BITS > MIN_SIM_BITS) ? SCORE_BITS : MIN_SIM_BITS;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic [KEEP_BITS-1:0]    keep_count_reg;
    logic [MIN_SIM_BITS-1:0] min_sim_reg;
    logic [CNT_W-1:0]        kept_count_reg;
    logic [CNT_W-1:0]        kept_count_next;
    logic                    state_reg;
    logic                    state_next;
    logic [REF_BITS-1:0]     owner_reg;

    logic                    rsp_valid_reg;
    logic                    rsp_valid_next;
    logic [REF_BITS-1:0]     rsp_ref_reg;
    logic [ID_BITS-1:0]      rsp_id_reg;
    logic [SCORE_BITS-1:0]   rsp_score_reg;
    logic                    rsp_last_reg;

    logic                    req_fire;
    logic                    do_insert;
    logic                    do_shift;
    logic [CNT_W-1:0]        limit;
    cell_mode_t              mode;

    logic [SCORE_BITS-1:0]   cell_score [CAPACITY];
    logic [ID_BITS-1:0]      cell_id    [CAPACITY];
    logic                    cell_gt    [CAPACITY];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg <= KEEP_COUNT_RST;
            min_sim_reg    <= MIN_SIM_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_KEEP_COUNT)
                keep_count_reg <= cfg_data[KEEP_BITS-1:0];
            else if (cfg_index == REG_MIN_SIM)
                min_sim_reg <= cfg_data[MIN_SIM_BITS-1:0];
        end
    end

    // Effective retention limit, clamped to 1..CAPACITY
    always_comb
    begin
        priority if (keep_count_reg == '0)
            limit = CNT_W'(1);
        else if (int'(keep_count_reg) > CAPACITY)
            limit = CNT_W'(CAPACITY);
        else
            limit = CNT_W'(keep_count_reg);
    end

    // Handshake and chain control
    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign do_insert = req_fire && (req.op == OP_OFFER)
                       && (CMP_W'(req.score) >= CMP_W'(min_sim_reg));
    assign do_shift  = (state_reg == ST_READ) && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        priority if (do_insert)
            mode = CM_INSERT;
        else if (do_shift)
            mode = CM_SHIFT;
        else
            mode = CM_HOLD;
    end

    // Sequencer: fill count doubles as the readout counter
    always_comb
    begin
        kept_count_next = kept_count_reg;
        state_next      = state_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (do_insert && (kept_count_reg < limit))
                    kept_count_next = kept_count_reg + CNT_W'(1);
                else if (req_fire && (req.op == OP_READOUT) && (kept_count_reg != '0))
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                if (do_shift)
                begin
                    rsp_valid_next  = 1'b1;
                    kept_count_next = kept_count_reg - CNT_W'(1);
                    if (kept_count_reg == CNT_W'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_count_reg <= '0;
            state_reg      <= ST_IDLE;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            kept_count_reg <= kept_count_next;
            state_reg      <= state_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Readout payload and held owner id
    always_ff @(posedge clk)
    begin
        if (req_fire && (req.op == OP_READOUT))
            owner_reg <= req.owner_id;
        if (do_shift)
        begin
            rsp_ref_reg   <= owner_reg;
            rsp_id_reg    <= cell_id[0];
            rsp_score_reg <= cell_score[0];
            rsp_last_reg  <= (kept_count_reg == CNT_W'(1));
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.ref_id      = rsp_ref_reg;
    assign rsp.entry_id    = rsp_id_reg;
    assign rsp.entry_score = rsp_score_reg;
    assign rsp.last        = rsp_last_reg;

    // Chain of cells, slot 0 holds the highest score
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        cell_ctl_t             ctl;
        logic                  left_gt;
        logic [SCORE_BITS-1:0] left_score;
        logic [ID_BITS-1:0]    left_id;
        logic [SCORE_BITS-1:0] right_score;
        logic [ID_BITS-1:0]    right_id;

        assign ctl.mode = mode;
        assign ctl.occ  = (CNT_W'(i) < kept_count_reg);

        if (i == 0)
        begin : g_head
            assign left_gt    = 1'b1;
            assign left_score = req.score;
            assign left_id    = req.item_id;
        end
        else
        begin : g_body
            assign left_gt    = cell_gt[i-1];
            assign left_score = cell_score[i-1];
            assign left_id    = cell_id[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_score = cell_score[i];
            assign right_id    = cell_id[i];
        end
        else
        begin : g_inner
            assign right_score = cell_score[i+1];
            assign right_id    = cell_id[i+1];
        end

        tkk_cell #(
            .SCORE_BITS (SCORE_BITS),
            .ID_BITS    (ID_BITS)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .offer_score (req.score),
            .offer_id    (req.item_id),
            .left_gt     (left_gt),
            .left_score  (left_score),
            .left_id     (left_id),
            .right_score (right_score),
            .right_id    (right_id),
            .gt          (cell_gt[i]),
            .score       (cell_score[i]),
            .id          (cell_id[i])
        );
    end

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(kept_count_reg) <= CAPACITY)
        else $error("fill count above capacity");

    a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (kept_count_reg != '0))
        else $error("readout active with empty list");

    a_mid_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_last_reg) |-> (state_reg == ST_READ))
        else $error("non-final result outside readout");

    a_read_start: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (req.op == OP_READOUT) && (kept_count_reg != '0))
        |=> (state_reg == ST_READ) && (kept_count_reg == $past(kept_count_reg)))
        else $error("readout did not start");

endmodule

`default_nettype wire

### test/tb.sv
// Self-checking bench for the top-k similarity keeper: directed table, a backpressure run, then random phases.
`timescale 1ns / 1ps

module tb;
    import tkk_pkg::*;

    localparam int SCORE_W      = SCORE_FRAC_BITS_DEF + 1;
    localparam int ID_W         = ID_BITS_DEF;
    localparam int KEEP_CAP     = CAPACITY_DEF;
    localparam int LONG_HOLD    = 150;
    localparam int DRAIN_CYCLES = 8;
    localparam int END_WAIT_MAX = 20000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 15;
    localparam int MAX_PRINTS   = 50;

    // Indexes that decode to no register; writes there must be ignored
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_3 = 2'd3;

    typedef enum logic {
        ROW_ITEM = 1'b0,
        ROW_REG  = 1'b1
    } row_kind_t;

    // One readout transaction as seen on rsp
    typedef struct packed {
        logic [REF_BITS-1:0] ref_id;
        logic [ID_W-1:0]     entry_id;
        logic [SCORE_W-1:0]  entry_score;
        logic                last;
    } hit_t;

    // One line of the directed table; typed rows carry their single result
    typedef struct packed {
        row_kind_t              kind;
        logic                   op;
        logic [SCORE_W-1:0]     score;
        logic [ID_W-1:0]        item_id;
        logic [REF_BITS-1:0]    owner_id;
        logic [CFG_IDX_BITS-1:0] reg_idx;
        logic [CFG_DATA_BITS-1:0] reg_val;
        logic                   typed;
        logic [ID_W-1:0]        hit_id;
        logic [SCORE_W-1:0]     hit_score;
    } row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    tkk_req_if #(.SCORE_BITS(SCORE_W), .ID_BITS(ID_W), .REF_BITS(REF_BITS)) req_ch ();
    tkk_rsp_if #(.SCORE_BITS(SCORE_W), .ID_BITS(ID_W), .REF_BITS(REF_BITS)) rsp_ch ();

    top_k_similarity_keeper_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Ranked list mirror: highest first, one spare slot for the entry about to go
    logic [SCORE_W-1:0]      ranked_score [0:KEEP_CAP];
    logic [ID_W-1:0]         ranked_id    [0:KEEP_CAP];
    int                      ranked_fill;
    logic [KEEP_BITS-1:0]    keep_reg;
    logic [MIN_SIM_BITS-1:0] floor_reg;

    hit_t due_hits [$];
    row_t script [$];
    int   mismatches;
    bit   tx_idle_on;
    bit   rx_idle_on;
    bit   long_hold_req;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("%0t: %s", $time, msg);
    endtask

    // Insert one offer: ahead of equal scores, then trim the lowest if over the limit
    function automatic void rank_offer(input logic [SCORE_W-1:0] s, input logic [ID_W-1:0] id);
        int pos;
        int i;
        int lim;
        if (s < floor_reg)
            return;
        pos = 0;
        while (pos < ranked_fill && ranked_score[pos] > s)
            pos++;
        for (i = ranked_fill; i > pos; i--)
        begin
            ranked_score[i] = ranked_score[i - 1];
            ranked_id[i]    = ranked_id[i - 1];
        end
        ranked_score[pos] = s;
        ranked_id[pos]    = id;
        ranked_fill++;
        lim = int'(keep_reg);
        if (lim < 1)
            lim = 1;
        if (lim > KEEP_CAP)
            lim = KEEP_CAP;
        if (ranked_fill > lim)
            ranked_fill--;
    endfunction

    // Readout: emit the whole list best first when asked to, then empty it
    function automatic void drain_ranking(input logic [REF_BITS-1:0] owner, input bit emit);
        int i;
        for (i = 0; i < ranked_fill; i++)
        begin
            if (emit)
                due_hits.push_back(hit_t'{ref_id: owner, entry_id: ranked_id[i],
                                          entry_score: ranked_score[i],
                                          last: (i == ranked_fill - 1)});
        end
        ranked_fill = 0;
    endfunction

    function automatic void apply_request(input row_t r);
        if (r.op == OP_OFFER)
            rank_offer(r.score, r.item_id);
        else if (r.typed)
        begin
            drain_ranking(r.owner_id, 1'b0);
            due_hits.push_back(hit_t'{ref_id: r.owner_id, entry_id: r.hit_id,
                                      entry_score: r.hit_score, last: 1'b1});
        end
        else
            drain_ranking(r.owner_id, 1'b1);
    endfunction

    function automatic row_t offer_row(input logic [SCORE_W-1:0] s, input logic [ID_W-1:0] id);
        row_t r;
        r          = '0;
        r.kind     = ROW_ITEM;
        r.op       = OP_OFFER;
        r.score    = s;
        r.item_id  = id;
        r.owner_id = ~id;
        return r;
    endfunction

    function automatic row_t read_row(input logic [REF_BITS-1:0] owner);
        row_t r;
        r          = '0;
        r.kind     = ROW_ITEM;
        r.op       = OP_READOUT;
        r.score    = SCORE_W'($urandom);
        r.item_id  = ~owner;
        r.owner_id = owner;
        return r;
    endfunction

    function automatic row_t read_one_row(input logic [REF_BITS-1:0] owner,
                                          input logic [ID_W-1:0] id,
                                          input logic [SCORE_W-1:0] s);
        row_t r;
        r           = read_row(owner);
        r.typed     = 1'b1;
        r.hit_id    = id;
        r.hit_score = s;
        return r;
    endfunction

    function automatic row_t reg_row(input logic [CFG_IDX_BITS-1:0] idx,
                                     input logic [CFG_DATA_BITS-1:0] val);
        row_t r;
        r         = '0;
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // Scores lean on ties and on both ends of the range
    function automatic logic [SCORE_W-1:0] pick_score();
        unique case ($urandom_range(0, 9))
            0:       return '0;
            1:       return SCORE_W'(65536);
            2, 3:    return SCORE_W'($urandom_range(0, 4) * 16384);
            4:       return SCORE_W'($urandom_range(0, 131071));
            default: return SCORE_W'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [KEEP_BITS-1:0] pick_keep();
        unique case ($urandom_range(0, 7))
            0:       return '0;
            1:       return KEEP_BITS'(1);
            2:       return KEEP_BITS'(KEEP_CAP);
            3:       return KEEP_BITS'($urandom_range(33, 63));
            default: return KEEP_BITS'($urandom_range(2, 31));
        endcase
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] pick_floor();
        unique case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CFG_DATA_BITS'(65536);
            2:       return CFG_DATA_BITS'($urandom);
            default: return CFG_DATA_BITS'($urandom_range(0, 4096));
        endcase
    endfunction

    // Offer one request and hold it until the block takes it
    task automatic send_request(input row_t r);
        int gap;
        gap = tx_idle_on ? int'($urandom_range(0, 10)) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.op       <= r.op;
        req_ch.score    <= r.score;
        req_ch.item_id  <= r.item_id;
        req_ch.owner_id <= r.owner_id;
        do
            @(posedge clk);
        while (!req_ch.ready);
        apply_request(r);
    endtask

    // Quiet the sender and let every outstanding result arrive
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (due_hits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        unique case (idx)
            REG_KEEP_COUNT: keep_reg  = val[KEEP_BITS-1:0];
            REG_MIN_SIM:    floor_reg = val[MIN_SIM_BITS-1:0];
            default:        ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_hit();
        hit_t want;
        if (due_hits.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result id %0h score %0h",
                                      rsp_ch.entry_id, rsp_ch.entry_score));
            return;
        end
        want = due_hits.pop_front();
        if (rsp_ch.ref_id !== want.ref_id)
            report_mismatch($sformatf("ref_id got %0h want %0h", rsp_ch.ref_id, want.ref_id));
        if (rsp_ch.entry_id !== want.entry_id)
            report_mismatch($sformatf("entry_id got %0h want %0h",
                                      rsp_ch.entry_id, want.entry_id));
        if (rsp_ch.entry_score !== want.entry_score)
            report_mismatch($sformatf("entry_score got %0h want %0h",
                                      rsp_ch.entry_score, want.entry_score));
        if (rsp_ch.last !== want.last)
            report_mismatch($sformatf("last got %0b want %0b", rsp_ch.last, want.last));
    endtask

    // Result side: random stalls, plus one long hold on request
    initial
    begin : rx_side
        int gap;
        gap = 0;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                check_hit();
                gap = rx_idle_on ? int'($urandom_range(0, 10)) : 0;
            end
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                gap = LONG_HOLD;
            end
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                gap--;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Stimulus
    initial
    begin : stim
        int ph;
        int n;
        int waited;
        logic [CFG_DATA_BITS-1:0] val;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        req_ch.valid    = 1'b0;
        req_ch.op       = OP_OFFER;
        req_ch.score    = '0;
        req_ch.item_id  = '0;
        req_ch.owner_id = '0;
        mismatches      = 0;
        long_hold_req   = 1'b0;
        tx_idle_on      = 1'b1;
        rx_idle_on      = 1'b1;
        keep_reg        = KEEP_COUNT_RST;
        floor_reg       = MIN_SIM_RST;
        ranked_fill     = 0;

        // Directed table
        script.push_back(read_row(32'h0000_0000));                 // empty list after reset
        script.push_back(reg_row(REG_UNUSED_2, 17'h1FFFF));        // dead indexes
        script.push_back(reg_row(REG_UNUSED_3, 17'h00000));
        script.push_back(offer_row(17'd0, 32'h0000_0001));         // below default floor
        script.push_back(read_row(32'hFFFF_FFFF));                 // still empty
        script.push_back(offer_row(17'h10000, 32'hFFFF_FFFF));
        script.push_back(read_one_row(32'hA5A5_A5A5, 32'hFFFF_FFFF, 17'h10000));
        script.push_back(offer_row(17'd1, 32'h0000_0000));         // exactly at floor
        script.push_back(read_one_row(32'h0000_0000, 32'h0000_0000, 17'd1));
        script.push_back(reg_row(REG_MIN_SIM, 17'd0));
        script.push_back(offer_row(17'd0, 32'h1234_5678));         // zero scores, equal tie
        script.push_back(offer_row(17'd0, 32'h0000_0009));
        script.push_back(read_row(32'h5A5A_5A5A));
        script.push_back(reg_row(REG_KEEP_COUNT, 17'd0));          // zero acts as one
        script.push_back(offer_row(17'd100, 32'h0000_0001));
        script.push_back(offer_row(17'd50, 32'h0000_0002));        // offer itself evicted
        script.push_back(offer_row(17'd100, 32'h0000_0003));       // newer tie wins
        script.push_back(read_one_row(32'hC3C3_C3C3, 32'h0000_0003, 17'd100));
        script.push_back(reg_row(REG_KEEP_COUNT, 17'h1FFFF));      // 63, clamps to capacity
        script.push_back(reg_row(REG_MIN_SIM, 17'h10000));         // floor at 1.0
        script.push_back(offer_row(17'hFFFF, 32'h0000_0004));
        script.push_back(offer_row(17'h10000, 32'h0000_0005));
        script.push_back(offer_row(17'h1FFFF, 32'h0000_0006));
        script.push_back(read_row(32'h3C3C_3C3C));
        script.push_back(reg_row(REG_MIN_SIM, 17'd0));
        script.push_back(reg_row(REG_KEEP_COUNT, 17'd3));
        script.push_back(offer_row(17'd200, 32'h0000_0010));
        script.push_back(offer_row(17'd300, 32'h0000_0011));
        script.push_back(offer_row(17'd200, 32'h0000_0012));
        script.push_back(offer_row(17'd100, 32'h0000_0013));
        script.push_back(offer_row(17'd200, 32'h0000_0014));
        script.push_back(reg_row(REG_KEEP_COUNT, 17'd1));          // limit drops below fill
        script.push_back(offer_row(17'd250, 32'h0000_0015));
        script.push_back(read_row(32'h0F0F_0F0F));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].kind == ROW_REG)
            begin
                settle();
                write_reg(script[i].reg_idx, script[i].reg_val);
            end
            else
                send_request(script[i]);
        end

        // Backpressure: fill the list, read out under a long result stall,
        // keep offering so the request side blocks
        settle();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        write_reg(REG_KEEP_COUNT, CFG_DATA_BITS'(KEEP_CAP));
        write_reg(REG_MIN_SIM, '0);
        for (n = 0; n < KEEP_CAP + 4; n++)
            send_request(offer_row(pick_score(), ID_W'($urandom)));
        send_request(read_row(REF_BITS'($urandom)));
        long_hold_req = 1'b1;
        for (n = 0; n < 10; n++)
            send_request(offer_row(pick_score(), ID_W'($urandom)));

        // Random phases, each under its own register setting and idling mix
        for (ph = 0; ph < PHASES; ph++)
        begin
            settle();
            val = CFG_DATA_BITS'($urandom);
            val[KEEP_BITS-1:0] = pick_keep();
            write_reg(REG_KEEP_COUNT, val);
            write_reg(REG_MIN_SIM, pick_floor());
            if ($urandom_range(0, 2) == 0)
                write_reg(($urandom_range(0, 1) == 0) ? REG_UNUSED_2 : REG_UNUSED_3,
                          CFG_DATA_BITS'($urandom));
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_request(read_row(REF_BITS'($urandom)));
                else
                    send_request(offer_row(pick_score(), ID_W'($urandom)));
            end
        end

        // Drain and finish
        req_ch.valid <= 1'b0;
        waited = 0;
        while (due_hits.size() != 0 && waited < END_WAIT_MAX)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (due_hits.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", due_hits.size()));
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
